### hw/rtl/tay_pkg.sv
// Shared types, widths and constants for the tilt angle and yaw integrator.
// No dependencies; every other file of the block imports this package.
package tay_pkg;

   localparam int ACC_W          = 16;        // accelerometer and gyro sample width
   localparam int CORDIC_W       = 27;        // CORDIC x, y and angle datapath width
   localparam int SQ_W           = 32;        // ay^2 + az^2
   localparam int ROOT_W         = 24;        // sqrt((ay^2 + az^2) << 16)
   localparam int ATAN_IDX_W     = 5;         // angle table index
   localparam int YAW_W          = 20;
   localparam int DEADBAND_W     = 15;
   localparam int PITCH_W        = 15;
   localparam int ROLL_W         = 16;
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 32;
   localparam int REQ_DATA_W     = 64;
   localparam int RSP_DATA_W     = 56;

   localparam int CORDIC_STEPS_DEFAULT = 16;
   localparam int ANG_HALF_TURN        = 11796480;   // 180 degrees in 1/65536 degree
   localparam int YAW_TURN             = 576000;     // 360 degrees in 1/1600 degree
   localparam int DEADBAND_RESET       = 16;
   localparam int PITCH_LIMIT          = 9000;
   localparam int ROLL_LIMIT           = 18000;
   localparam int CENTI_SCALE          = 100;
   localparam int CENTI_ROUND          = 32768;

   // register index, taken from the word address
   localparam logic CSR_IDX_DEADBAND = 1'b0;

   typedef struct packed {
      logic                        start;
      logic signed [CORDIC_W-1:0]  x;
      logic signed [CORDIC_W-1:0]  y;
      logic signed [CORDIC_W-1:0]  z;
   } cordic_cmd_type;

   // atan(2^-i) in degrees times 65536, rounded to nearest
   function automatic logic signed [CORDIC_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
      logic signed [CORDIC_W-1:0] val;
      case (idx)
         5'd0:    val = 27'sd2949120;
         5'd1:    val = 27'sd1740967;
         5'd2:    val = 27'sd919879;
         5'd3:    val = 27'sd466945;
         5'd4:    val = 27'sd234379;
         5'd5:    val = 27'sd117304;
         5'd6:    val = 27'sd58666;
         5'd7:    val = 27'sd29335;
         5'd8:    val = 27'sd14668;
         5'd9:    val = 27'sd7334;
         5'd10:   val = 27'sd3667;
         5'd11:   val = 27'sd1833;
         5'd12:   val = 27'sd917;
         5'd13:   val = 27'sd458;
         5'd14:   val = 27'sd229;
         5'd15:   val = 27'sd115;
         5'd16:   val = 27'sd57;
         5'd17:   val = 27'sd29;
         5'd18:   val = 27'sd14;
         5'd19:   val = 27'sd7;
         5'd20:   val = 27'sd4;
         5'd21:   val = 27'sd2;
         5'd22:   val = 27'sd1;
         default: val = 27'sd0;
      endcase
      return val;
   endfunction

endpackage

### hw/rtl/tay_isqrt.sv
// Iterative floor square root of (radicand << 16), one result bit per cycle.
// Depends on tay_pkg for the operand and root widths.
module tay_isqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [tay_pkg::SQ_W-1:0]   radicand,
   output logic                       busy,
   output logic [tay_pkg::ROOT_W-1:0] root
);
   import tay_pkg::*;

   localparam int VAL_W = 2 * ROOT_W;
   localparam int REM_W = ROOT_W + 2;
   localparam int TRY_W = ROOT_W + 4;
   localparam int CNT_W = $clog2(ROOT_W);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(ROOT_W - 1);

   logic                busy_ff, busy_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [VAL_W-1:0]    val_ff, val_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [ROOT_W-1:0]   root_ff, root_in;
   logic [TRY_W-1:0]    rem_shift;
   logic [TRY_W-1:0]    trial;

   always_comb begin
      rem_shift = {rem_ff, val_ff[VAL_W-1 -: 2]};
      trial     = {2'b00, root_ff, 2'b01};
      busy_in   = busy_ff;
      cnt_in    = cnt_ff;
      val_in    = val_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         val_in  = {radicand, (VAL_W - SQ_W)'(0)};
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         // take the next bit pair, keep the trial subtraction when it fits
         val_in = {val_ff[VAL_W-3:0], 2'b00};
         if (rem_shift >= trial) begin
            rem_in  = REM_W'(rem_shift - trial);
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = REM_W'(rem_shift);
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign busy = busy_ff;
   assign root = root_ff;

endmodule

### hw/rtl/tay_cordic.sv
// Vectoring CORDIC, one micro-rotation per cycle, shared by roll and pitch.
// Depends on tay_pkg for the datapath width and the angle table.
module tay_cordic #(
   parameter int STEPS = tay_pkg::CORDIC_STEPS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  tay_pkg::cordic_cmd_type            cmd,
   output logic                               busy,
   output logic signed [tay_pkg::CORDIC_W-1:0] angle
);
   import tay_pkg::*;

   localparam int CNT_W = $clog2(STEPS);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

   logic                        busy_ff, busy_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic signed [CORDIC_W-1:0]  x_ff, x_in;
   logic signed [CORDIC_W-1:0]  y_ff, y_in;
   logic signed [CORDIC_W-1:0]  z_ff, z_in;
   logic signed [CORDIC_W-1:0]  xs;
   logic signed [CORDIC_W-1:0]  ys;
   logic signed [CORDIC_W-1:0]  atan_val;

   always_comb begin
      xs       = x_ff >>> cnt_ff;
      ys       = y_ff >>> cnt_ff;
      atan_val = atan_entry(ATAN_IDX_W'(cnt_ff));
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         x_in    = cmd.x;
         y_in    = cmd.y;
         z_in    = cmd.z;
      end else if (busy_ff) begin
         // rotate toward the x axis, accumulate the angle turned
         if (!y_ff[CORDIC_W-1]) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + atan_val;
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - atan_val;
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign busy  = busy_ff;
   assign angle = z_ff;

endmodule

### hw/rtl/tilt_angles_and_yaw_integrator.sv
// Top level: sample sequencer, yaw integration, angle conversion and APB register.
// Depends on tay_pkg, tay_isqrt and tay_cordic.
//
//   channel | direction | transfer when            | contents
//   req_    | in        | req_tvalid & req_tready  | accel_x, accel_y, accel_z, gyro_z
//   rsp_    | out       | rsp_tvalid & rsp_tready  | pitch_centideg, roll_centideg, yaw_angle
//   csr_    | in/out    | psel & penable & pwrite  | gyro_deadband at byte address 0
//
// Each sample runs through the setup states S_SQ_A, S_SQ_B and S_ROOT, the 24-step square
// root (roll CORDIC alongside), the roll conversion states S_ROLL_MAG and S_ROLL_CENTI, the
// pitch CORDIC pass, the pitch conversion states S_PITCH_MAG and S_PITCH_CENTI, and the
// output load. req_tready is high only in idle, so no sample is taken while one is worked on.
// The result register holds a finished sample while the next one is worked on; a stalled
// rsp_ side holds the sequencer at its last step. Reset clears yaw and sets the deadband to 16.
module tilt_angles_and_yaw_integrator #(
   parameter int CORDIC_STEPS = tay_pkg::CORDIC_STEPS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // accel_x [15:0], accel_y [31:16], accel_z [47:32], gyro_z [63:48]
   input  logic [tay_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // pitch_centideg [14:0], roll_centideg [30:15], yaw_angle [50:31], zero [55:51]
   output logic [tay_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [tay_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [tay_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [tay_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import tay_pkg::*;

   localparam int SUM_W  = YAW_W + 2;
   localparam int MAG_W  = CORDIC_W;
   localparam int PROD_W = MAG_W + 7;
   localparam int CENT_W = PROD_W - 16;
   localparam int PAD_W  = CORDIC_W - ACC_W - 8;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SQ_A,
      S_SQ_B,
      S_ROOT,
      S_WAIT,
      S_ROLL_MAG,
      S_ROLL_CENTI,
      S_PITCH_WAIT,
      S_PITCH_MAG,
      S_PITCH_CENTI,
      S_DONE
   } state_type;

   state_type                  state_ff, state_in;
   logic [DEADBAND_W-1:0]      deadband_ff, deadband_in;
   logic [YAW_W-1:0]           yaw_ff, yaw_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   logic signed [ACC_W-1:0]    ax_ff, ay_ff, az_ff, gz_ff;
   logic [SQ_W-1:0]            sq_ff, sq_in;
   logic [MAG_W-1:0]           mag_ff, mag_in;
   logic                       neg_ff, neg_in;
   logic signed [ROLL_W-1:0]   roll_ff, roll_in;
   logic signed [PITCH_W-1:0]  pitch_ff, pitch_in;
   logic [PITCH_W-1:0]         out_pitch_ff;
   logic [ROLL_W-1:0]          out_roll_ff;
   logic [YAW_W-1:0]           out_yaw_ff;

   logic                       req_fire;
   logic                       csr_write;
   logic                       out_free;
   logic                       root_start;
   logic                       root_busy;
   logic [ROOT_W-1:0]          root;
   cordic_cmd_type             cordic_cmd;
   logic                       cordic_busy;
   logic signed [CORDIC_W-1:0] cordic_angle;

   logic signed [CORDIC_W-1:0] ax_w, ay_w, az_w;
   logic signed [ACC_W-1:0]    mul_op;
   logic signed [2*ACC_W-1:0]  mul_prod;
   logic                       roll_zero, pitch_zero;
   logic [ACC_W:0]             gz_abs;
   logic signed [SUM_W-1:0]    yaw_sum;
   logic [PROD_W-1:0]          centi_prod;
   logic [CENT_W-1:0]          centi_raw;
   logic [ROLL_W-2:0]          centi_lim;
   logic [ROLL_W-2:0]          centi_mag;
   logic signed [ROLL_W-1:0]   centi_val;

   assign req_fire  = req_tvalid && req_tready;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign out_free  = !rsp_valid_ff || rsp_tready;

   // sign-extended and scaled by 256 for the CORDIC datapath
   assign ax_w = {{PAD_W{ax_ff[ACC_W-1]}}, ax_ff, 8'h00};
   assign ay_w = {{PAD_W{ay_ff[ACC_W-1]}}, ay_ff, 8'h00};
   assign az_w = {{PAD_W{az_ff[ACC_W-1]}}, az_ff, 8'h00};

   assign roll_zero  = (ay_ff == '0) && (az_ff == '0);
   assign pitch_zero = roll_zero && (ax_ff == '0);

   assign mul_op   = (state_ff == S_SQ_A) ? ay_ff : az_ff;
   assign mul_prod = mul_op * mul_op;

   // yaw: integrate outside the deadband, then wrap once into one turn
   always_comb begin
      gz_abs  = gz_ff[ACC_W-1] ? (ACC_W+1)'(-{gz_ff[ACC_W-1], gz_ff})
                               : {1'b0, gz_ff};
      yaw_sum = signed'({2'b00, yaw_ff});
      if (gz_abs > {2'b00, deadband_ff}) begin
         yaw_sum = yaw_sum + SUM_W'(gz_ff);
      end
      if (yaw_sum < 0) begin
         yaw_sum = yaw_sum + signed'(SUM_W'(YAW_TURN));
      end else if (yaw_sum >= signed'(SUM_W'(YAW_TURN))) begin
         yaw_sum = yaw_sum - signed'(SUM_W'(YAW_TURN));
      end
   end

   // angle magnitude to centidegrees, rounded, clamped, sign restored
   always_comb begin
      centi_prod = PROD_W'(mag_ff) * PROD_W'(CENTI_SCALE) + PROD_W'(CENTI_ROUND);
      centi_raw  = centi_prod[PROD_W-1:16];
      centi_lim  = (state_ff == S_ROLL_CENTI) ? (ROLL_W-1)'(ROLL_LIMIT)
                                               : (ROLL_W-1)'(PITCH_LIMIT);
      centi_mag  = (centi_raw > CENT_W'(centi_lim)) ? centi_lim
                                                     : centi_raw[ROLL_W-2:0];
      centi_val  = neg_ff ? -signed'({1'b0, centi_mag}) : signed'({1'b0, centi_mag});
   end

   always_comb begin
      cordic_cmd.start = 1'b0;
      cordic_cmd.x     = az_w;
      cordic_cmd.y     = ay_w;
      cordic_cmd.z     = '0;
      if (state_ff == S_SQ_A) begin
         cordic_cmd.start = 1'b1;
         // negative z: turn the vector by half a turn first
         if (az_ff[ACC_W-1]) begin
            cordic_cmd.x = -az_w;
            cordic_cmd.y = -ay_w;
            cordic_cmd.z = ay_ff[ACC_W-1] ? -CORDIC_W'(ANG_HALF_TURN)
                                          : CORDIC_W'(ANG_HALF_TURN);
         end
      end else if (state_ff == S_ROLL_CENTI) begin
         cordic_cmd.start = 1'b1;
         cordic_cmd.x     = signed'(CORDIC_W'(root));
         cordic_cmd.y     = ax_w;
      end
   end

   assign root_start = (state_ff == S_ROOT);

   always_comb begin
      state_in     = state_ff;
      deadband_in  = deadband_ff;
      yaw_in       = yaw_ff;
      rsp_valid_in = rsp_valid_ff;
      sq_in        = sq_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      roll_in      = roll_ff;
      pitch_in     = pitch_ff;
      if (csr_write && (csr_paddr[2] == CSR_IDX_DEADBAND)) begin
         deadband_in = csr_pwdata[DEADBAND_W-1:0];
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_SQ_A;
            end
         end
         S_SQ_A: begin
            sq_in    = SQ_W'(unsigned'(mul_prod));
            yaw_in   = yaw_sum[YAW_W-1:0];
            state_in = S_SQ_B;
         end
         S_SQ_B: begin
            sq_in    = sq_ff + SQ_W'(unsigned'(mul_prod));
            state_in = S_ROOT;
         end
         S_ROOT: begin
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (!root_busy && !cordic_busy) begin
               state_in = S_ROLL_MAG;
            end
         end
         S_ROLL_MAG: begin
            neg_in   = cordic_angle[CORDIC_W-1];
            mag_in   = neg_in ? MAG_W'(-cordic_angle) : MAG_W'(cordic_angle);
            state_in = S_ROLL_CENTI;
         end
         S_ROLL_CENTI: begin
            roll_in  = roll_zero ? '0 : centi_val;
            state_in = S_PITCH_WAIT;
         end
         S_PITCH_WAIT: begin
            if (!cordic_busy) begin
               state_in = S_PITCH_MAG;
            end
         end
         S_PITCH_MAG: begin
            // pitch is the negated angle
            neg_in   = (cordic_angle > 0);
            mag_in   = cordic_angle[CORDIC_W-1] ? MAG_W'(-cordic_angle)
                                                : MAG_W'(cordic_angle);
            state_in = S_PITCH_CENTI;
         end
         S_PITCH_CENTI: begin
            pitch_in = pitch_zero ? '0 : centi_val[PITCH_W-1:0];
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         deadband_ff  <= DEADBAND_W'(DEADBAND_RESET);
         yaw_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         deadband_ff  <= deadband_in;
         yaw_ff       <= yaw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         ax_ff <= req_tdata[15:0];
         ay_ff <= req_tdata[31:16];
         az_ff <= req_tdata[47:32];
         gz_ff <= req_tdata[63:48];
      end
      sq_ff    <= sq_in;
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      roll_ff  <= roll_in;
      pitch_ff <= pitch_in;
      if ((state_ff == S_DONE) && out_free) begin
         out_pitch_ff <= pitch_ff;
         out_roll_ff  <= roll_ff;
         out_yaw_ff   <= yaw_ff;
      end
   end

   tay_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (sq_ff),
      .busy     (root_busy),
      .root     (root)
   );

   tay_cordic #(
      .STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .cmd   (cordic_cmd),
      .busy  (cordic_busy),
      .angle (cordic_angle)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - YAW_W - ROLL_W - PITCH_W)'(0),
                        out_yaw_ff, out_roll_ff, out_pitch_ff};
   assign csr_pready = 1'b1;
   assign csr_prdata = CSR_DATA_W'(deadband_ff);

   a_yaw_in_turn: assert property (@(posedge clock) disable iff (reset)
      yaw_ff < YAW_W'(YAW_TURN))
      else $error("yaw accumulator left one turn");

   a_cordic_idle_start: assert property (@(posedge clock) disable iff (reset)
      cordic_cmd.start |-> !cordic_busy)
      else $error("CORDIC started while busy");

   a_root_idle_start: assert property (@(posedge clock) disable iff (reset)
      root_start |-> !root_busy)
      else $error("square root started while busy");

   a_roll_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((signed'(out_roll_ff) <= 16'sd18000) &&
                        (signed'(out_roll_ff) >= -16'sd18000)))
      else $error("roll result out of range");

endmodule
